// ===== rtl/assert_macros.svh =====
// Assertion macros used by the top level of the prefix span locator.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define PSL_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("psl assertion failed");

// Next-cycle implication, disabled while reset is low.
`define PSL_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("psl assertion failed");

`endif

// ===== rtl/psl_pkg.sv =====
// Shared widths, codes and result type of the prefix span locator.
package psl_pkg;

  localparam int unsigned DEF_MAX_ROWS = 512;

  localparam int unsigned OP_W     = 2;
  localparam int unsigned STEP_W   = 20;
  localparam int unsigned SLOT_W   = 30;
  localparam int unsigned ROW_W    = 9;
  localparam int unsigned OFF_W    = 33;
  localparam int unsigned CFG_W    = 32;
  localparam int unsigned CFG_IDX_W = 1;

  // Register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_BASE    = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_SCRATCH = 1'b1;

  typedef enum logic [OP_W-1:0] {
    OP_APPEND = 2'd0,
    OP_FIND   = 2'd1,
    OP_GET    = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_FULL = 2'd1,
    ST_MISS = 2'd2
  } status_e;

  // Result handed from the core to the output stage
  typedef struct packed {
    logic [ROW_W-1:0]  row;
    logic [SLOT_W-1:0] rel_slot;
    logic [SLOT_W-1:0] bit_rel;
    logic              has_off;
    status_e           status;
  } res_t;

endpackage

// ===== rtl/prefix_span_locator.sv =====
// Top level of the prefix span locator: configuration, output stage, checks.
//
//   channel  direction  handshake                 payload
//   in       input      in_valid_i / in_ready_o   op, row_steps, row_bits, slot, row_select
//   out      output     out_valid_o / out_ready_i row_index, within_slot, bit_offset,
//                                                 region_fits, status
//   cfg      input      cfg_we_i (no wait)        cfg_idx_i, cfg_wdata_i
//
// One item at a time. Appends and absent-row queries go straight to the result,
// a row query reads its row first, and a slot query runs a binary search paced
// by the single read port of the row memory: one probe per cycle.
// The output register lets the next item enter while a result waits.
// Reset clears the row count, totals and config registers; the row memory needs no clearing.
module prefix_span_locator #(
  parameter int unsigned MAX_ROWS = psl_pkg::DEF_MAX_ROWS
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [psl_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [psl_pkg::CFG_W-1:0]     cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [psl_pkg::OP_W-1:0]      op_i,
  input  logic [psl_pkg::STEP_W-1:0]    row_steps_i,
  input  logic [psl_pkg::STEP_W-1:0]    row_bits_i,
  input  logic [psl_pkg::SLOT_W-1:0]    slot_i,
  input  logic [psl_pkg::ROW_W-1:0]     row_select_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [psl_pkg::ROW_W-1:0]     row_index_o,
  output logic [psl_pkg::SLOT_W-1:0]    within_slot_o,
  output logic [psl_pkg::OFF_W-1:0]     bit_offset_o,
  output logic                          region_fits_o,
  output logic [1:0]                    status_o
);
  import psl_pkg::*;
`include "assert_macros.svh"

  logic [CFG_W-1:0]  base_q, scratch_q;
  res_t              res;
  logic              res_valid, res_take;
  logic [SLOT_W-1:0] bit_total;
  logic              out_valid_q;
  logic [ROW_W-1:0]  row_index_q;
  logic [SLOT_W-1:0] rel_slot_q;
  logic [OFF_W-1:0]  bit_offset_q;
  logic              fits_q;
  status_e           status_q;
  logic [OFF_W-1:0]  region_end;

  psl_core #(
    .MAX_ROWS (MAX_ROWS)
  ) u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .op_i         (op_i),
    .row_steps_i  (row_steps_i),
    .row_bits_i   (row_bits_i),
    .slot_i       (slot_i),
    .row_select_i (row_select_i),
    .res_valid_o  (res_valid),
    .res_ready_i  (res_take),
    .res_o        (res),
    .bit_total_o  (bit_total)
  );

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q    <= '0;
      scratch_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_BASE:    base_q    <= cfg_wdata_i;
        REG_SCRATCH: scratch_q <= cfg_wdata_i;
        default: begin
        end
      endcase
    end
  end

  // Move a result into the output stage when it is empty or being drained
  assign res_take   = res_valid && (!out_valid_q || out_ready_i);
  assign region_end = OFF_W'(base_q) + OFF_W'(bit_total);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_take) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_take) begin
      row_index_q  <= res.row;
      rel_slot_q   <= res.rel_slot;
      bit_offset_q <= res.has_off ? (OFF_W'(base_q) + OFF_W'(res.bit_rel)) : '0;
      fits_q       <= (region_end <= OFF_W'(scratch_q));
      status_q     <= res.status;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign row_index_o   = row_index_q;
  assign within_slot_o = rel_slot_q;
  assign bit_offset_o  = bit_offset_q;
  assign region_fits_o = fits_q;
  assign status_o      = status_q;

  // Checks
  `PSL_ASSERT_NOW(a_ok_has_offset, clk_i, rst_ni, res_valid, (res.status == ST_OK) == res.has_off)
  `PSL_ASSERT_NOW(a_busy_while_result, clk_i, rst_ni, res_valid, !in_ready_o)
  `PSL_ASSERT_NEXT(a_busy_after_accept, clk_i, rst_ni, in_valid_i && in_ready_o, !in_ready_o)
  `PSL_ASSERT_NEXT(a_take_fills_out, clk_i, rst_ni, res_take, out_valid_o)

endmodule

// ===== rtl/psl_core.sv =====
// Row table memory, running totals and the binary search sequencer.
module psl_core #(
  parameter int unsigned MAX_ROWS = psl_pkg::DEF_MAX_ROWS
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [psl_pkg::OP_W-1:0]    op_i,
  input  logic [psl_pkg::STEP_W-1:0]  row_steps_i,
  input  logic [psl_pkg::STEP_W-1:0]  row_bits_i,
  input  logic [psl_pkg::SLOT_W-1:0]  slot_i,
  input  logic [psl_pkg::ROW_W-1:0]   row_select_i,
  output logic                        res_valid_o,
  input  logic                        res_ready_i,
  output psl_pkg::res_t               res_o,
  output logic [psl_pkg::SLOT_W-1:0]  bit_total_o
);
  import psl_pkg::*;

  localparam int unsigned IDX_W = $clog2(MAX_ROWS);
  localparam int unsigned CNT_W = $clog2(MAX_ROWS + 1);
  localparam int unsigned CMP_W = (CNT_W > ROW_W) ? CNT_W : ROW_W;
  localparam int unsigned MEM_W = 2 * SLOT_W;

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_SEARCH = 4'b0010,
    S_GET    = 4'b0100,
    S_RESP   = 4'b1000
  } state_e;

  state_e             state_q, state_d;
  logic [CNT_W-1:0]   row_count_q, row_count_d;
  logic [SLOT_W-1:0]  slot_total_q, slot_total_d;
  logic [SLOT_W-1:0]  bit_total_q, bit_total_d;
  logic [CNT_W-1:0]   lo_q, lo_d, hi_q, hi_d;
  logic [IDX_W-1:0]   mid_q, mid_d;
  logic [SLOT_W-1:0]  slot_q, slot_d;
  logic [SLOT_W-1:0]  best_slot_q, best_slot_d;
  logic [SLOT_W-1:0]  best_bit_q, best_bit_d;
  logic [ROW_W-1:0]   row_q, row_d;
  logic               is_find_q, is_find_d;
  logic               has_off_q, has_off_d;
  status_e            status_q, status_d;

  logic [MEM_W-1:0]   mem_q [MAX_ROWS];
  logic [MEM_W-1:0]   rdata_q;
  logic               rd_en, we;
  logic [IDX_W-1:0]   rd_addr;
  logic [SLOT_W-1:0]  rd_slot, rd_bit;
  logic [CNT_W-1:0]   lo_n, hi_n;
  logic [SLOT_W:0]    slot_sum, bit_sum;

  assign rd_slot = rdata_q[MEM_W-1:SLOT_W];
  assign rd_bit  = rdata_q[SLOT_W-1:0];

  // Saturating running totals for the next append
  assign slot_sum = {1'b0, slot_total_q} + (SLOT_W+1)'(row_steps_i);
  assign bit_sum  = {1'b0, bit_total_q} + (SLOT_W+1)'(row_bits_i);

  // Row memory: the append writes the new row at the accept edge; a probe can
  // only be issued in a later cycle, so a read never meets a pending write.
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[IDX_W'(row_count_q)] <= {slot_total_q, bit_total_q};
    end
    if (rd_en) begin
      rdata_q <= mem_q[rd_addr];
    end
  end

  // Sequencer: accept, probe one row per cycle, then hold the result
  always_comb begin
    state_d      = state_q;
    row_count_d  = row_count_q;
    slot_total_d = slot_total_q;
    bit_total_d  = bit_total_q;
    lo_d         = lo_q;
    hi_d         = hi_q;
    mid_d        = mid_q;
    slot_d       = slot_q;
    best_slot_d  = best_slot_q;
    best_bit_d   = best_bit_q;
    row_d        = row_q;
    is_find_d    = is_find_q;
    has_off_d    = has_off_q;
    status_d     = status_q;
    rd_en        = 1'b0;
    rd_addr      = '0;
    we           = 1'b0;
    lo_n         = lo_q;
    hi_n         = hi_q;
    in_ready_o   = 1'b0;
    res_valid_o  = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          slot_d    = slot_i;
          row_d     = '0;
          is_find_d = 1'b0;
          has_off_d = 1'b0;
          status_d  = ST_MISS;
          state_d   = S_RESP;
          case (op_i)
            OP_APPEND: begin
              if (row_count_q == CNT_W'(MAX_ROWS)) begin
                status_d = ST_FULL;
              end else begin
                we           = 1'b1;
                row_d        = ROW_W'(row_count_q);
                best_bit_d   = bit_total_q;
                has_off_d    = 1'b1;
                status_d     = ST_OK;
                row_count_d  = row_count_q + 1'b1;
                slot_total_d = slot_sum[SLOT_W] ? '1 : slot_sum[SLOT_W-1:0];
                bit_total_d  = bit_sum[SLOT_W] ? '1 : bit_sum[SLOT_W-1:0];
              end
            end
            OP_FIND: begin
              if (row_count_q != '0) begin
                lo_d      = '0;
                hi_d      = row_count_q;
                mid_d     = IDX_W'(row_count_q >> 1);
                rd_en     = 1'b1;
                rd_addr   = IDX_W'(row_count_q >> 1);
                is_find_d = 1'b1;
                has_off_d = 1'b1;
                status_d  = ST_OK;
                state_d   = S_SEARCH;
              end
            end
            OP_GET: begin
              row_d = row_select_i;
              if (CMP_W'(row_select_i) < CMP_W'(row_count_q)) begin
                rd_en     = 1'b1;
                rd_addr   = IDX_W'(row_select_i);
                has_off_d = 1'b1;
                status_d  = ST_OK;
                state_d   = S_GET;
              end
            end
            default: begin
              status_d = ST_MISS;
            end
          endcase
        end
      end
      S_SEARCH: begin
        // Keep the last row whose start is at or below the slot
        if (rd_slot <= slot_q) begin
          row_d       = ROW_W'(mid_q);
          best_slot_d = rd_slot;
          best_bit_d  = rd_bit;
          lo_n        = CNT_W'(mid_q) + 1'b1;
        end else begin
          hi_n = CNT_W'(mid_q);
        end
        lo_d = lo_n;
        hi_d = hi_n;
        if (lo_n < hi_n) begin
          mid_d   = IDX_W'(lo_n + ((hi_n - lo_n) >> 1));
          rd_en   = 1'b1;
          rd_addr = IDX_W'(lo_n + ((hi_n - lo_n) >> 1));
        end else begin
          state_d = S_RESP;
        end
      end
      S_GET: begin
        best_bit_d = rd_bit;
        state_d    = S_RESP;
      end
      S_RESP: begin
        res_valid_o = 1'b1;
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      row_count_q  <= '0;
      slot_total_q <= '0;
      bit_total_q  <= '0;
    end else begin
      state_q      <= state_d;
      row_count_q  <= row_count_d;
      slot_total_q <= slot_total_d;
      bit_total_q  <= bit_total_d;
    end
  end

  // Search and result payload
  always_ff @(posedge clk_i) begin
    lo_q        <= lo_d;
    hi_q        <= hi_d;
    mid_q       <= mid_d;
    slot_q      <= slot_d;
    best_slot_q <= best_slot_d;
    best_bit_q  <= best_bit_d;
    row_q       <= row_d;
    is_find_q   <= is_find_d;
    has_off_q   <= has_off_d;
    status_q    <= status_d;
  end

  // Result fields
  always_comb begin
    res_o.row      = row_q;
    res_o.rel_slot = is_find_q ? (slot_q - best_slot_q) : '0;
    res_o.bit_rel  = best_bit_q;
    res_o.has_off  = has_off_q;
    res_o.status   = status_q;
  end

  assign bit_total_o = bit_total_q;

endmodule

// ===== dv/tb_top.sv =====
// Testbench of the prefix span locator: row table tracker, beat drivers and result checks.
`timescale 1ns / 100ps

module tb_top;
  import psl_pkg::*;

  localparam int unsigned ROWS = DEF_MAX_ROWS;
  localparam logic [OP_W-1:0] OP_SPARE = 2'd3;
  localparam logic [SLOT_W-1:0] SLOT_MAX = '1;
  localparam logic [STEP_W-1:0] STEP_MAX = '1;
  localparam logic [CFG_W-1:0] CFG_MAX = '1;
  localparam int unsigned TAIL_CYCLES = 40;
  localparam int unsigned NO_PAUSE = 32'hFFFF_FFFF;
  localparam longint unsigned RUN_LIMIT_NS = 5_000_000;

  // One input beat
  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [STEP_W-1:0] steps;
    logic [STEP_W-1:0] bits;
    logic [SLOT_W-1:0] slot;
    logic [ROW_W-1:0]  sel;
  } request_t;

  // One expected output beat
  typedef struct packed {
    logic [ROW_W-1:0]  row;
    logic [SLOT_W-1:0] rel_slot;
    logic [OFF_W-1:0]  off;
    logic              fits;
    status_e           status;
  } span_t;

  // Mirror of the row table: prefix starts, totals and registers
  class row_table_tracker;
    logic [SLOT_W-1:0] slot_base [ROWS];
    logic [SLOT_W-1:0] bit_base [ROWS];
    int unsigned       row_count;
    logic [SLOT_W-1:0] slot_total;
    logic [SLOT_W-1:0] bit_total;
    logic [CFG_W-1:0]  base_reg;
    logic [CFG_W-1:0]  scratch_reg;
    span_t             pending_spans [$];
    int unsigned       mismatch_count;

    function new();
      row_count = 0;
      slot_total = '0;
      bit_total = '0;
      base_reg = '0;
      scratch_reg = '0;
      mismatch_count = 0;
    endfunction

    function void set_regs(logic [CFG_W-1:0] base, logic [CFG_W-1:0] scratch);
      base_reg = base;
      scratch_reg = scratch;
    endfunction

    // Clamp running sums at the top of the 30-bit range
    function logic [SLOT_W-1:0] sat_sum(logic [SLOT_W-1:0] acc, logic [STEP_W-1:0] add);
      logic [SLOT_W:0] s;
      s = {1'b0, acc} + (SLOT_W + 1)'(add);
      return s[SLOT_W] ? SLOT_MAX : s[SLOT_W-1:0];
    endfunction

    function logic [OFF_W-1:0] place(logic [SLOT_W-1:0] rel);
      return OFF_W'(base_reg) + OFF_W'(rel);
    endfunction

    // Find the last row whose start slot is at or below s
    function int unsigned last_row_at(logic [SLOT_W-1:0] s);
      int unsigned lo;
      int unsigned hi;
      int unsigned mid;
      int unsigned hit;
      lo = 0;
      hi = row_count;
      hit = 0;
      while (lo < hi) begin
        mid = lo + (hi - lo) / 2;
        if (slot_base[mid] <= s) begin
          hit = mid;
          lo = mid + 1;
        end else begin
          hi = mid;
        end
      end
      return hit;
    endfunction

    // Advance the table for an accepted beat and queue its expected result
    function void log_request(request_t r);
      span_t s;
      int unsigned hit;
      s = '0;
      s.status = ST_OK;
      case (r.op)
        OP_APPEND: begin
          if (row_count >= ROWS) begin
            s.status = ST_FULL;
          end else begin
            slot_base[row_count] = slot_total;
            bit_base[row_count] = bit_total;
            slot_total = sat_sum(slot_total, r.steps);
            bit_total = sat_sum(bit_total, r.bits);
            s.row = ROW_W'(row_count);
            s.off = place(bit_base[row_count]);
            row_count++;
          end
        end
        OP_FIND: begin
          if (row_count == 0) begin
            s.status = ST_MISS;
          end else begin
            hit = last_row_at(r.slot);
            s.row = ROW_W'(hit);
            s.rel_slot = r.slot - slot_base[hit];
            s.off = place(bit_base[hit]);
          end
        end
        OP_GET: begin
          s.row = r.sel;
          if (r.sel >= row_count) begin
            s.status = ST_MISS;
          end else begin
            s.off = place(bit_base[r.sel]);
          end
        end
        default: begin
          s.status = ST_MISS;
        end
      endcase
      s.fits = (OFF_W'(base_reg) + OFF_W'(bit_total)) <= OFF_W'(scratch_reg);
      pending_spans.push_back(s);
    endfunction

    function void compare_field(string field, logic [OFF_W-1:0] want, logic [OFF_W-1:0] got);
      if (want !== got) begin
        mismatch_count++;
        $display("%0t: %s expected 0x%0h actual 0x%0h", $time, field, want, got);
      end
    endfunction

    // Match an output beat against the oldest expectation
    function void check_span(logic [ROW_W-1:0] row, logic [SLOT_W-1:0] rel_slot,
                             logic [OFF_W-1:0] off, logic fits, logic [1:0] status);
      span_t want;
      if (pending_spans.size() == 0) begin
        mismatch_count++;
        $display("%0t: unexpected result, expected none actual row %0d status %0d",
                 $time, row, status);
        return;
      end
      want = pending_spans.pop_front();
      compare_field("row_index", OFF_W'(want.row), OFF_W'(row));
      compare_field("within_slot", OFF_W'(want.rel_slot), OFF_W'(rel_slot));
      compare_field("bit_offset", want.off, off);
      compare_field("region_fits", OFF_W'(want.fits), OFF_W'(fits));
      compare_field("status", OFF_W'(want.status), OFF_W'(status));
    endfunction
  endclass

  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [CFG_W-1:0]     cfg_wdata_i = '0;
  logic                 in_valid_i = 1'b0;
  logic                 in_ready_o;
  logic [OP_W-1:0]      op_i = '0;
  logic [STEP_W-1:0]    row_steps_i = '0;
  logic [STEP_W-1:0]    row_bits_i = '0;
  logic [SLOT_W-1:0]    slot_i = '0;
  logic [ROW_W-1:0]     row_select_i = '0;
  logic                 out_valid_o;
  logic                 out_ready_i = 1'b0;
  logic [ROW_W-1:0]     row_index_o;
  logic [SLOT_W-1:0]    within_slot_o;
  logic [OFF_W-1:0]     bit_offset_o;
  logic                 region_fits_o;
  logic [1:0]           status_o;

  bit calm = 1'b0;
  row_table_tracker tracker;

  prefix_span_locator i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .op_i          (op_i),
    .row_steps_i   (row_steps_i),
    .row_bits_i    (row_bits_i),
    .slot_i        (slot_i),
    .row_select_i  (row_select_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .row_index_o   (row_index_o),
    .within_slot_o (within_slot_o),
    .bit_offset_o  (bit_offset_o),
    .region_fits_o (region_fits_o),
    .status_o      (status_o)
  );

  // Clock: 12 ns period
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  function automatic request_t compose(logic [OP_W-1:0] op, logic [STEP_W-1:0] steps,
                                       logic [STEP_W-1:0] bits, logic [SLOT_W-1:0] slot,
                                       logic [ROW_W-1:0] sel);
    request_t r;
    r.op = op;
    r.steps = steps;
    r.bits = bits;
    r.slot = slot;
    r.sel = sel;
    return r;
  endfunction

  // Favor zero, full-scale and tiny costs
  function automatic logic [STEP_W-1:0] shape_cost();
    case ($urandom_range(0, 9))
      0, 1:    return '0;
      2:       return STEP_MAX;
      3:       return STEP_W'($urandom_range(1, 3));
      default: return STEP_W'($urandom());
    endcase
  endfunction

  // Draw a random beat, aiming slots and rows at the interesting spots of the table
  function automatic request_t pick_request(int unsigned append_pct);
    request_t r;
    int unsigned n;
    logic [SLOT_W-1:0] start;
    n = tracker.row_count;
    r.op = OP_SPARE;
    r.steps = shape_cost();
    r.bits = shape_cost();
    r.slot = SLOT_W'($urandom());
    r.sel = ROW_W'($urandom());
    if ($urandom_range(0, 99) < append_pct) begin
      r.op = OP_APPEND;
    end else begin
      case ($urandom_range(0, 19))
        0: r.op = OP_SPARE;
        1, 2, 3, 4, 5, 6, 7, 8: r.op = OP_GET;
        default: r.op = OP_FIND;
      endcase
    end
    if (n > 0) begin
      start = tracker.slot_base[$urandom_range(0, n - 1)];
      case ($urandom_range(0, 9))
        0, 1, 2: r.slot = start;
        3:       r.slot = start - 1'b1;
        4, 5, 6: r.slot = SLOT_W'($urandom_range(0, tracker.slot_total + 16));
        7:       r.slot = SLOT_MAX;
        default: ;
      endcase
    end
    case ($urandom_range(0, 7))
      0, 1, 2: if (n > 0) r.sel = ROW_W'($urandom_range(0, n - 1));
      3:       r.sel = ROW_W'(n);
      4:       r.sel = $urandom_range(0, 1) ? '1 : '0;
      default: ;
    endcase
    return r;
  endfunction

  // Present one beat, with an occasional idle burst ahead of it
  task automatic send_item(input request_t r);
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    op_i <= r.op;
    row_steps_i <= r.steps;
    row_bits_i <= r.bits;
    slot_i <= r.slot;
    row_select_i <= r.sel;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    tracker.log_request(r);
  endtask

  // Hold the input side until every queued result has come back
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (tracker.pending_spans.size() != 0) @(posedge clk_i);
  endtask

  task automatic load_regs(input logic [CFG_W-1:0] base, input logic [CFG_W-1:0] scratch);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= REG_BASE;
    cfg_wdata_i <= base;
    @(posedge clk_i);
    cfg_idx_i <= REG_SCRATCH;
    cfg_wdata_i <= scratch;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    tracker.set_regs(base, scratch);
  endtask

  // Reprogram while idle, then stream random beats
  task automatic run_phase(input logic [CFG_W-1:0] base, input logic [CFG_W-1:0] scratch,
                           input int unsigned append_pct, input int unsigned count,
                           input int unsigned fill_to, input int unsigned pause_at);
    wait_drained();
    load_regs(base, scratch);
    for (int unsigned k = 0; k < count || tracker.row_count < fill_to; k++) begin
      if (k == pause_at) wait_drained();
      send_item(pick_request(append_pct));
    end
  endtask

  // Output side: check each accepted beat, stall in random bursts
  initial begin : result_sink
    int unsigned hold;
    hold = 0;
    forever begin
      @(posedge clk_i);
      if (out_valid_o && out_ready_i) begin
        tracker.check_span(row_index_o, within_slot_o, bit_offset_o, region_fits_o, status_o);
      end
      if (hold != 0) begin
        hold--;
        out_ready_i <= 1'b0;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        hold = $urandom_range(0, 6);
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= 1'b1;
      end
    end
  end

  initial begin : stimulus
    logic [CFG_W-1:0] base;
    tracker = new();
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Queries on an empty table and the spare op, registers at reset values
    send_item(compose(OP_FIND, '0, '0, '0, '0));
    send_item(compose(OP_FIND, '0, '0, SLOT_MAX, '0));
    send_item(compose(OP_GET, '0, '0, '0, '0));
    send_item(compose(OP_GET, '0, '0, '0, '1));
    send_item(compose(OP_SPARE, '1, '1, '1, '1));

    // Build a short table with zero-cost rows and full-scale costs
    send_item(compose(OP_APPEND, '0, '0, '0, '0));
    send_item(compose(OP_APPEND, '0, STEP_MAX, '0, '0));
    send_item(compose(OP_APPEND, STEP_MAX, STEP_MAX, '0, '0));
    send_item(compose(OP_APPEND, '0, 20'd1, '0, '0));
    send_item(compose(OP_APPEND, 20'd1, '0, '0, '0));
    send_item(compose(OP_APPEND, 20'd5, 20'd7, '0, '0));
    send_item(compose(OP_APPEND, '0, 20'd3, '0, '0));

    // Searches across shared starts, row edges and past the total
    send_item(compose(OP_FIND, '0, '0, '0, '0));
    send_item(compose(OP_FIND, '0, '0, SLOT_W'(STEP_MAX), '0));
    send_item(compose(OP_FIND, '0, '0, SLOT_W'(STEP_MAX) - 1'b1, '0));
    send_item(compose(OP_FIND, '0, '0, tracker.slot_total, '0));
    send_item(compose(OP_FIND, '1, '1, SLOT_MAX, '1));

    // Row queries: first, last, just absent, top index
    send_item(compose(OP_GET, '0, '0, '0, '0));
    send_item(compose(OP_GET, '0, '0, '0, ROW_W'(tracker.row_count - 1)));
    send_item(compose(OP_GET, '0, '0, '0, ROW_W'(tracker.row_count)));
    send_item(compose(OP_GET, '1, '1, '1, '1));
    send_item(compose(OP_SPARE, '0, '0, '0, '0));
    send_item(compose(OP_APPEND, 20'd2, 20'd2, SLOT_MAX, '1));

    // Random phases across register settings; the third one fills the table
    base = CFG_W'($urandom_range(0, 1000));
    run_phase(base, CFG_MAX - CFG_W'($urandom_range(0, 255)), 60, 60, 0, NO_PAUSE);
    run_phase(CFG_MAX, CFG_MAX, 60, 60, 0, 40);
    run_phase('0, '0, 95, 60, ROWS, NO_PAUSE);
    base = CFG_W'($urandom_range(0, 1000));
    run_phase(base, base + CFG_W'(tracker.bit_total) - 1'b1, 30, 40, 0, NO_PAUSE);
    wait_drained();
    calm = 1'b1;
    base = CFG_W'($urandom());
    run_phase(base, base + CFG_W'(tracker.bit_total), 30, 40, 0, NO_PAUSE);

    // Drain, let the pipeline settle, report
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (tracker.mismatch_count == 0 && tracker.pending_spans.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Watchdog
  initial begin : watchdog
    #(RUN_LIMIT_NS);
    $display("end of test: mismatches");
    $finish;
  end

endmodule
